// ===== hw/rtl/rbls_pkg.sv =====
`default_nettype none

package rbls_pkg;

  localparam int RELAY_COUNT = 10;
  localparam int SP_W        = $clog2(RELAY_COUNT);
  localparam int IDX_W       = 4;
  localparam int CMD_W       = 3;
  localparam int MASK_W      = 10;
  localparam int SETTLE_W    = 10;
  localparam int CHECK_W     = 8;

  localparam int IN_W        = CMD_W + IDX_W + 1;
  localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = MASK_W + IDX_W + 3;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(100);
  localparam logic [CHECK_W-1:0]  CHECK_RESET  = CHECK_W'(60);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 3'd0,
    CMD_RESET = 3'd1,
    CMD_SHED  = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_COUNT = 3'd5
  } cmd_t;

  typedef enum logic {
    REG_SETTLE_TICKS = 1'b0,
    REG_CHECK_LIMIT  = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/relay_bank_with_last_on_shedding.sv =====
// Relay bank with last-on shedding.
// Command transactions arrive on s_tvalid/s_tready/s_tdata; every command
// produces exactly one result transaction on m_tvalid/m_tready/m_tdata
// carrying the relay mask, the relay dropped by a shed, the acknowledged
// change flag, the settled flag and the current-check timeout flag.
// The stack of recently enabled relays lives in a small synchronous RAM.
// A command is accepted while the RAM entry at the stack pointer is read;
// the execute state then applies the command and loads the output register.
// A new command is accepted only after the previous one has been applied.
// If the receiver stalls, the finished result waits in the output register
// and the block holds the next accepted command until the register frees.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the settle
// tick count (index 0) and the check limit (index 1); the user must make
// them only while idle, as the block itself does not enforce this.
// Reset (rst, synchronous) turns all relays off, empties the stack through
// its valid bits, marks the bank as settled and restores the register
// defaults of 100 ticks and a limit of 60.
`default_nettype none

module relay_bank_with_last_on_shedding (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // cmd[2:0], relay_index[6:3], ack_changed[7]
  input  wire logic [rbls_pkg::IN_BYTES_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // relay_mask[9:0], shed_relay[13:10], changed_seen[14], settled[15],
  // check_timeout[16], zero fill above
  output logic [rbls_pkg::OUT_BYTES_W-1:0]       m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [rbls_pkg::SETTLE_W-1:0]     cfg_data
);

  localparam int RC = rbls_pkg::RELAY_COUNT;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t st;

  logic [rbls_pkg::SETTLE_W-1:0] settle_ticks;
  logic [rbls_pkg::CHECK_W-1:0]  check_limit;

  logic [RC-1:0]                 relay_bits, relay_bits_next;
  logic [rbls_pkg::SP_W-1:0]     sp, sp_next;
  logic                          change_pending, change_pending_next;
  logic                          settle_done, settle_done_next;
  logic [rbls_pkg::SETTLE_W-1:0] settle_count, settle_count_next;
  logic [rbls_pkg::CHECK_W-1:0]  check_count, check_count_next;

  // Latched command.
  logic [rbls_pkg::CMD_W-1:0]    cmd_q;
  logic [rbls_pkg::IDX_W-1:0]    idx_q;
  logic                          ack_q;

  // Recent stack RAM and per-entry valid bits.
  logic [rbls_pkg::IDX_W-1:0]    stack_mem [RC];
  logic [RC-1:0]                 stack_vld;
  logic [rbls_pkg::IDX_W-1:0]    mem_q;
  logic                          vld_q;

  logic                          wr_en;
  logic                          vld_clr_one;
  logic                          vld_clr_all;
  logic [rbls_pkg::IDX_W-1:0]    shed_val;
  logic                          seen;
  logic                          idx_ok;
  logic [rbls_pkg::SP_W-1:0]     ri;
  logic [rbls_pkg::SP_W-1:0]     shed_ri;
  logic [rbls_pkg::SP_W-1:0]     sp_inc;
  logic [rbls_pkg::SP_W-1:0]     sp_dec;
  logic                          exec_go;
  logic [RC+rbls_pkg::MASK_W-1:0] mask_pad;

  assign s_tready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign exec_go   = (st == S_EXEC) && (!m_tvalid || m_tready);

  assign idx_ok  = idx_q < rbls_pkg::IDX_W'(RC);
  assign ri      = idx_q[rbls_pkg::SP_W-1:0];
  assign shed_ri = mem_q[rbls_pkg::SP_W-1:0];
  assign sp_inc  = (sp == rbls_pkg::SP_W'(RC - 1)) ? '0 : sp + 1'b1;
  assign sp_dec  = (sp == '0) ? rbls_pkg::SP_W'(RC - 1) : sp - 1'b1;

  always_comb begin
    relay_bits_next     = relay_bits;
    sp_next             = sp;
    change_pending_next = change_pending;
    settle_done_next    = settle_done;
    settle_count_next   = settle_count;
    check_count_next    = check_count;
    wr_en               = 1'b0;
    vld_clr_one         = 1'b0;
    vld_clr_all         = 1'b0;
    shed_val            = rbls_pkg::IDX_W'(RC);
    seen                = 1'b0;
    unique case (cmd_q)
      rbls_pkg::CMD_SET: begin
        if (idx_ok) begin
          if (!relay_bits[ri]) begin
            change_pending_next = 1'b1;
          end
          relay_bits_next[ri] = 1'b1;
          sp_next             = sp_inc;
          wr_en               = 1'b1;
          check_count_next    = '0;
          settle_done_next    = 1'b0;
          settle_count_next   = settle_ticks;
        end
      end
      rbls_pkg::CMD_RESET: begin
        if (idx_ok) begin
          if (relay_bits[ri]) begin
            change_pending_next = 1'b1;
          end
          relay_bits_next[ri] = 1'b0;
          settle_done_next    = 1'b0;
          settle_count_next   = settle_ticks;
        end
      end
      rbls_pkg::CMD_SHED: begin
        // Valid entries always hold a relay number below the bank size.
        if (vld_q) begin
          shed_val = mem_q;
          if (relay_bits[shed_ri]) begin
            change_pending_next = 1'b1;
          end
          relay_bits_next[shed_ri] = 1'b0;
          settle_done_next         = 1'b0;
          settle_count_next        = settle_ticks;
        end
        vld_clr_one = 1'b1;
        sp_next     = sp_dec;
      end
      rbls_pkg::CMD_TICK: begin
        if (!settle_done) begin
          if (settle_count <= rbls_pkg::SETTLE_W'(1)) begin
            settle_done_next  = 1'b1;
            settle_count_next = '0;
          end else begin
            settle_count_next = settle_count - 1'b1;
          end
        end
      end
      rbls_pkg::CMD_CLEAR: begin
        vld_clr_all = 1'b1;
        sp_next     = '0;
      end
      rbls_pkg::CMD_COUNT: begin
        if (check_count != '1) begin
          check_count_next = check_count + 1'b1;
        end
      end
      default: begin
      end
    endcase
    // The acknowledge sees the flag after the command has acted.
    if (ack_q) begin
      seen                = change_pending_next;
      change_pending_next = 1'b0;
    end
  end

  assign mask_pad = {{rbls_pkg::MASK_W{1'b0}}, relay_bits_next};

  // Stack RAM: one read port at the stack pointer, one write port.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mem_q <= stack_mem[sp];
    end
    if (exec_go && wr_en) begin
      stack_mem[sp_next] <= idx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_vld <= '0;
      vld_q     <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        vld_q <= stack_vld[sp];
      end
      if (exec_go) begin
        if (vld_clr_all) begin
          stack_vld <= '0;
        end else if (vld_clr_one) begin
          stack_vld[sp] <= 1'b0;
        end else if (wr_en) begin
          stack_vld[sp_next] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= rbls_pkg::SETTLE_RESET;
      check_limit  <= rbls_pkg::CHECK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbls_pkg::REG_SETTLE_TICKS: settle_ticks <= cfg_data;
        rbls_pkg::REG_CHECK_LIMIT:  check_limit  <= cfg_data[rbls_pkg::CHECK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      m_tvalid       <= 1'b0;
      relay_bits     <= '0;
      sp             <= '0;
      change_pending <= 1'b0;
      settle_done    <= 1'b1;
      settle_count   <= '0;
      check_count    <= '0;
    end else begin
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= s_tdata[rbls_pkg::CMD_W-1:0];
            idx_q <= s_tdata[rbls_pkg::CMD_W +: rbls_pkg::IDX_W];
            ack_q <= s_tdata[rbls_pkg::CMD_W + rbls_pkg::IDX_W];
            st    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            relay_bits     <= relay_bits_next;
            sp             <= sp_next;
            change_pending <= change_pending_next;
            settle_done    <= settle_done_next;
            settle_count   <= settle_count_next;
            check_count    <= check_count_next;
            m_tdata        <= rbls_pkg::OUT_BYTES_W'({
                                check_count_next >= check_limit,
                                settle_done_next,
                                seen,
                                shed_val,
                                mask_pad[rbls_pkg::MASK_W-1:0]});
            st             <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Only one command is in flight: acceptance is followed by a busy cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("command accepted while previous one still executing");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= rbls_pkg::SP_W'(RC - 1))
    else $error("stack pointer beyond bank size");

  a_settle_idle: assert property (@(posedge clk) disable iff (rst)
    settle_done |-> (settle_count == '0))
    else $error("settle counter running while settled");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/relay_bank_with_last_on_shedding_tb.sv =====
`default_nettype none

module relay_bank_with_last_on_shedding_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIRECTED_N  = 24;
  localparam int PHASE_N     = 6;
  localparam int FILL_W      = rbls_pkg::OUT_BYTES_W - rbls_pkg::OUT_W;

  localparam logic [rbls_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [rbls_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [rbls_pkg::IDX_W-1:0] NO_RELAY   =
    rbls_pkg::IDX_W'(rbls_pkg::RELAY_COUNT);

  typedef struct packed {
    logic                          check_timeout;
    logic                          settled;
    logic                          changed_seen;
    logic [rbls_pkg::IDX_W-1:0]    shed_relay;
    logic [rbls_pkg::MASK_W-1:0]   relay_mask;
  } relay_status_t;

  typedef struct packed {
    logic [rbls_pkg::CMD_W-1:0] cmd;
    logic [rbls_pkg::IDX_W-1:0] idx;
    logic                       ack;
    logic                       typed;
    relay_status_t              want;
  } stim_row_t;

  typedef enum int {MIX_GENERAL, MIX_COUNTING, MIX_STACKING} mix_t;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_t;

  localparam relay_status_t NO_STATUS = '0;

  // Rows with typed = 1 carry an expectation that follows directly from the
  // reset state; the rest are predicted.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{rbls_pkg::CMD_TICK,  4'd0,  1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, NO_RELAY, 10'h000}},
    '{rbls_pkg::CMD_SHED,  4'd0,  1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, NO_RELAY, 10'h000}},
    '{rbls_pkg::CMD_SET,   4'd0,  1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, NO_RELAY, 10'h001}},
    '{rbls_pkg::CMD_SET,   4'd9,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SET,   4'd15, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, NO_RELAY, 10'h201}},
    '{rbls_pkg::CMD_SET,   4'd10, 1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_RESET, 4'd12, 1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SET,   4'd9,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SHED,  4'd0,  1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SHED,  4'd0,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SHED,  4'd0,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SHED,  4'd0,  1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_COUNT, 4'd0,  1'b1, 1'b0, NO_STATUS},
    '{CMD_SPARE6,          4'd5,  1'b0, 1'b0, NO_STATUS},
    '{CMD_SPARE7,          4'd15, 1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_RESET, 4'd0,  1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SET,   4'd3,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SET,   4'd4,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SET,   4'd5,  1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_CLEAR, 4'd0,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_SHED,  4'd0,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_RESET, 4'd3,  1'b1, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_TICK,  4'd0,  1'b0, 1'b0, NO_STATUS},
    '{rbls_pkg::CMD_COUNT, 4'd15, 1'b1, 1'b0, NO_STATUS}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rbls_pkg::IN_BYTES_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [rbls_pkg::OUT_BYTES_W-1:0] m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_index = 1'b0;
  logic [rbls_pkg::SETTLE_W-1:0]    cfg_data = '0;

  // Side information that travels with the command being driven.
  logic                             drive_typed = 1'b0;
  relay_status_t                    drive_want = '0;

  // Predictor state and its copy of the configuration.
  logic [rbls_pkg::MASK_W-1:0]      bank_on;
  logic [rbls_pkg::IDX_W-1:0]       recent [16];
  int unsigned                      stack_top;
  logic                             change_flag;
  logic                             settled_flag;
  logic [rbls_pkg::SETTLE_W-1:0]    settle_cnt;
  logic [rbls_pkg::CHECK_W-1:0]     check_cnt;
  logic [rbls_pkg::SETTLE_W-1:0]    settle_ticks_cfg;
  logic [rbls_pkg::CHECK_W-1:0]     check_limit_cfg;

  relay_status_t                    pending_status [$];
  int                               mismatch_count = 0;
  int                               cycle_count = 0;
  int                               burst_left = 1;
  bit                               steady = 1'b0;
  ready_mode_t                      ready_mode = READY_ALWAYS;
  int                               ready_left = 0;
  int                               ready_tick = 0;

  // Settings and command mix of each random phase.
  int                               phase_settle [PHASE_N] = '{1, 0, 1023, 3, 0, 2};
  int                               phase_limit  [PHASE_N] = '{0, 255, 1, 5, 0, 60};
  int                               phase_items  [PHASE_N] = '{300, 400, 250, 300, 300, 250};
  bit                               phase_steady [PHASE_N] =
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
  mix_t                             phase_mix    [PHASE_N] =
    '{MIX_GENERAL, MIX_COUNTING, MIX_GENERAL, MIX_STACKING, MIX_GENERAL, MIX_STACKING};

  relay_bank_with_last_on_shedding dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void drop_relay(logic [rbls_pkg::IDX_W-1:0] r);
    if (r < rbls_pkg::RELAY_COUNT) begin
      if (bank_on[r]) change_flag = 1'b1;
      bank_on[r] = 1'b0;
      settled_flag = 1'b0;
      settle_cnt = settle_ticks_cfg;
    end
  endfunction

  function automatic relay_status_t apply_command(logic [rbls_pkg::CMD_W-1:0] cmd,
                                                  logic [rbls_pkg::IDX_W-1:0] idx,
                                                  logic ack);
    relay_status_t              res;
    logic [rbls_pkg::IDX_W-1:0] shed;
    logic [rbls_pkg::IDX_W-1:0] entry;
    logic                       seen;
    shed = NO_RELAY;
    seen = 1'b0;
    case (cmd)
      rbls_pkg::CMD_SET: begin
        if (idx < rbls_pkg::RELAY_COUNT) begin
          if (!bank_on[idx]) change_flag = 1'b1;
          bank_on[idx] = 1'b1;
          // The entry is pushed even when the relay was already on.
          stack_top = (stack_top + 1) % rbls_pkg::RELAY_COUNT;
          recent[stack_top] = idx;
          check_cnt = '0;
          settled_flag = 1'b0;
          settle_cnt = settle_ticks_cfg;
        end
      end
      rbls_pkg::CMD_RESET: drop_relay(idx);
      rbls_pkg::CMD_SHED: begin
        entry = recent[stack_top];
        shed = (entry >= rbls_pkg::RELAY_COUNT) ? NO_RELAY : entry;
        drop_relay(shed);
        recent[stack_top] = NO_RELAY;
        stack_top = (stack_top == 0) ? rbls_pkg::RELAY_COUNT - 1 : stack_top - 1;
      end
      rbls_pkg::CMD_TICK: begin
        if (!settled_flag) begin
          // A settle count of zero expires on the first tick, like one.
          if (settle_cnt <= 1) begin
            settled_flag = 1'b1;
            settle_cnt = '0;
          end else begin
            settle_cnt = settle_cnt - 1'b1;
          end
        end
      end
      rbls_pkg::CMD_CLEAR: begin
        for (int i = 0; i < 16; i++) recent[i] = NO_RELAY;
        stack_top = 0;
      end
      rbls_pkg::CMD_COUNT: if (check_cnt != '1) check_cnt = check_cnt + 1'b1;
      default: ;
    endcase
    // The acknowledge sees the flag after the command has taken effect.
    if (ack) begin
      seen = change_flag;
      change_flag = 1'b0;
    end
    res.relay_mask    = bank_on;
    res.shed_relay    = shed;
    res.changed_seen  = seen;
    res.settled       = settled_flag;
    res.check_timeout = (check_cnt >= check_limit_cfg);
    return res;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(logic [rbls_pkg::CMD_W-1:0] cmd, logic [rbls_pkg::IDX_W-1:0] idx,
                           logic ack, logic typed, relay_status_t want);
    int gap;
    s_tvalid    <= 1'b1;
    s_tdata     <= rbls_pkg::IN_BYTES_W'({ack, idx, cmd});
    drive_typed <= typed;
    drive_want  <= want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  // Writes both registers back to back; the block must be idle.
  task automatic write_settings(logic [rbls_pkg::SETTLE_W-1:0] settle,
                                logic [rbls_pkg::SETTLE_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= rbls_pkg::REG_SETTLE_TICKS;
    cfg_data  <= settle;
    do @(posedge clk); while (!cfg_ready);
    settle_ticks_cfg = settle;
    @(negedge clk);
    cfg_index <= rbls_pkg::REG_CHECK_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    check_limit_cfg = limit[rbls_pkg::CHECK_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 96);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:  m_tready <= 1'b1;
      READY_COIN:    m_tready <= 1'($urandom_range(0, 1));
      READY_PATTERN: m_tready <= (ready_tick % 5) < 3;
      default:       m_tready <= (ready_tick % 8) == 0;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL relay_bank_with_last_on_shedding");
      $finish;
    end
  end

  always @(posedge clk) begin
    relay_status_t want;
    relay_status_t predicted;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result transaction with nothing expected: %h", m_tdata);
        end else begin
          want = pending_status.pop_front();
          if (m_tdata !== {{FILL_W{1'b0}}, want}) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: mask %h/%h shed %0d/%0d seen %b/%b settled %b/%b ",
                        "timeout %b/%b fill %h (expected/actual)"},
                       want.relay_mask, m_tdata[9:0], want.shed_relay, m_tdata[13:10],
                       want.changed_seen, m_tdata[14], want.settled, m_tdata[15],
                       want.check_timeout, m_tdata[16],
                       m_tdata[rbls_pkg::OUT_BYTES_W-1:rbls_pkg::OUT_W]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predicted = apply_command(s_tdata[2:0], s_tdata[6:3], s_tdata[7]);
        pending_status.push_back(drive_typed ? drive_want : predicted);
      end
    end
  end

  initial begin
    int                         roll;
    logic [rbls_pkg::CMD_W-1:0] cmd;
    logic [rbls_pkg::IDX_W-1:0] idx;
    logic                       ack;

    bank_on          = '0;
    for (int i = 0; i < 16; i++) recent[i] = NO_RELAY;
    stack_top        = 0;
    change_flag      = 1'b0;
    settled_flag     = 1'b1;
    settle_cnt       = '0;
    check_cnt        = '0;
    settle_ticks_cfg = rbls_pkg::SETTLE_RESET;
    check_limit_cfg  = rbls_pkg::CHECK_RESET;

    phase_settle[4] = $urandom_range(1, 20);
    phase_limit[4]  = $urandom_range(0, 16);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The directed part runs on the reset defaults.
    for (int r = 0; r < DIRECTED_N; r++)
      send_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].ack,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    wait_idle();

    for (int p = 0; p < PHASE_N; p++) begin
      write_settings(rbls_pkg::SETTLE_W'(phase_settle[p]),
                     rbls_pkg::SETTLE_W'(phase_limit[p]));
      steady = phase_steady[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        roll = $urandom_range(0, 99);
        case (phase_mix[p])
          MIX_COUNTING:
            cmd = roll < 80 ? rbls_pkg::CMD_COUNT :
                  roll < 88 ? rbls_pkg::CMD_TICK :
                  roll < 93 ? rbls_pkg::CMD_SHED :
                  roll < 97 ? rbls_pkg::CMD_RESET :
                  roll < 99 ? rbls_pkg::CMD_CLEAR : CMD_SPARE7;
          MIX_STACKING:
            cmd = roll < 40 ? rbls_pkg::CMD_SET :
                  roll < 75 ? rbls_pkg::CMD_SHED :
                  roll < 80 ? rbls_pkg::CMD_RESET :
                  roll < 85 ? rbls_pkg::CMD_CLEAR :
                  roll < 95 ? rbls_pkg::CMD_TICK : rbls_pkg::CMD_COUNT;
          default:
            cmd = roll < 25 ? rbls_pkg::CMD_SET :
                  roll < 37 ? rbls_pkg::CMD_RESET :
                  roll < 55 ? rbls_pkg::CMD_SHED :
                  roll < 75 ? rbls_pkg::CMD_TICK :
                  roll < 80 ? rbls_pkg::CMD_CLEAR :
                  roll < 97 ? rbls_pkg::CMD_COUNT :
                  roll < 99 ? CMD_SPARE6 : CMD_SPARE7;
        endcase
        // Mostly valid relay numbers, with some out-of-range ones mixed in.
        idx = ($urandom_range(0, 99) < 85)
              ? rbls_pkg::IDX_W'($urandom_range(0, rbls_pkg::RELAY_COUNT - 1))
              : rbls_pkg::IDX_W'($urandom_range(rbls_pkg::RELAY_COUNT, 15));
        ack = ($urandom_range(0, 99) < 30);
        send_item(cmd, idx, ack, 1'b0, NO_STATUS);
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("PASS relay_bank_with_last_on_shedding");
    end else begin
      $display("FAIL relay_bank_with_last_on_shedding");
    end
    $finish;
  end

endmodule

`default_nettype wire
